// ===== rtl/ipr_pkg.sv =====
// Shared types and constants for the influence prune/renormalize block.
// No dependencies; imported by every module of the block.
package ipr_pkg;

    localparam int BW       = 8;      // bone index width
    localparam int WW       = 17;     // Q1.16 weight width
    localparam int SW       = 20;     // sum of up to eight weights
    localparam int LW       = 4;      // influence limit register width
    localparam int Q_DEPTH  = 4;      // entry queue depth
    localparam int QPW      = 2;      // queue pointer width
    localparam int QCW      = 3;      // queue fill count width
    localparam int DIV_BITS = 17;     // quotient bits per division

    localparam logic [LW-1:0] KEEP_CAP = 4'd8;

    // register indexes on the configuration port
    localparam logic REG_MAX_INF = 1'b0;
    localparam logic REG_THRESH  = 1'b1;

    // one queued beat from the front end
    typedef struct packed {
        logic [BW-1:0] bone;
        logic [WW-1:0] weight;
        logic          last;
        logic          keep;   // entry fits in the store
    } t_entry;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SELECT,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/ipr_front.sv =====
// Front end: accepts input beats and marks entries that overflow the store.
// Depends on ipr_pkg.
module ipr_front import ipr_pkg::*; #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  logic [BW-1:0] i_bone_in,
    input  logic [WW-1:0] i_weight_in,
    input  logic          i_last_in,
    output logic          o_wr,
    output t_entry        o_item
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CW-1:0] r_fcnt;
    logic [CW-1:0] n_fcnt;
    logic          keep;

    assign o_wr = i_push && !i_full;
    assign keep = (r_fcnt < CW'(MAX_ENTRIES));

    assign o_item.bone   = i_bone_in;
    assign o_item.weight = i_weight_in;
    assign o_item.last   = i_last_in;
    assign o_item.keep   = keep;

    // count entries of the current vertex, restart after the last one
    always_comb begin
        n_fcnt = r_fcnt;
        if (o_wr) begin
            if (i_last_in) begin
                n_fcnt = '0;
            end else if (keep) begin
                n_fcnt = r_fcnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
        end else begin
            r_fcnt <= n_fcnt;
        end
    end

endmodule

// ===== rtl/ipr_queue.sv =====
// Short entry queue between the front end and the back end.
// Depends on ipr_pkg.
module ipr_queue import ipr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_item,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_take,
    output t_entry o_item
);

    t_entry           r_mem [Q_DEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    logic             rd;

    assign o_full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign rd      = i_take && o_valid;

    // store beats
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + QPW'(1);
            end
            r_cnt <= r_cnt + QCW'(i_wr) - QCW'(rd);
        end
    end

endmodule

// ===== rtl/ipr_back.sv =====
// Back end: sorted insert, selection, serial division and result register.
// Depends on ipr_pkg.
module ipr_back import ipr_pkg::*; #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_entry        i_item,
    output logic          o_take,
    input  logic [LW-1:0] i_limit,
    input  logic [WW-1:0] i_thresh,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [BW-1:0] o_bone_out,
    output logic [WW-1:0] o_weight_out,
    output logic          o_last_out
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    t_state        r_state;
    t_state        n_state;
    logic [BW-1:0] r_bone [MAX_ENTRIES];
    logic [WW-1:0] r_wt   [MAX_ENTRIES];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_kept;
    logic [SW-1:0] r_sum;
    logic [SW:0]   r_rem;
    logic          r_lsb;
    logic [4:0]    r_bitcnt;
    logic [WW-1:0] r_quo;
    logic          r_out_vld;
    logic [BW-1:0] r_out_bone;
    logic [WW-1:0] r_out_wt;
    logic          r_out_last;

    logic [IW-1:0] rd_idx;
    logic [IW-1:0] nx_idx;
    logic [WW-1:0] cur_wt;
    logic [WW-1:0] nx_wt;
    logic          sel_ok;
    logic          div_done;
    logic          out_free;
    logic          emit_last;
    logic          take_beat;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          qbit;
    logic [MAX_ENTRIES-1:0] ge;

    assign rd_idx    = r_idx[IW-1:0];
    assign nx_idx    = IW'(r_idx + CW'(1));
    assign cur_wt    = r_wt[rd_idx];
    assign nx_wt     = r_wt[nx_idx];
    assign out_free  = !r_out_vld || i_pop;
    assign emit_last = (r_idx + CW'(1) == r_kept);
    assign div_done  = (r_sum == '0) || (r_bitcnt == 5'(DIV_BITS - 1));
    assign take_beat = o_take && i_valid;

    // keep while under the limit; all but the first must meet the threshold
    assign sel_ok = (r_idx < r_cnt) && (r_kept < CW'(i_limit))
                    && !((cur_wt < i_thresh) && (r_kept != '0));

    // one restoring division step
    always_comb begin
        trial = {r_rem[SW-1:0], (r_bitcnt == '0) ? r_lsb : 1'b0};
        diff  = trial - {1'b0, r_sum};
        qbit  = (trial >= {1'b0, r_sum});
    end

    // stored entries at or above the new weight stay in place
    always_comb begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            ge[j] = (CW'(j) < r_cnt) && (r_wt[j] >= i_item.weight);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (take_beat && i_item.last) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (!sel_ok) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = emit_last ? ST_LOAD : ST_DIV;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_take = (r_state == ST_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // insert beats in descending weight order, stable on ties
    always_ff @(posedge i_clk) begin
        if (take_beat && i_item.keep) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                if (!ge[j]) begin
                    if (j == 0 || ge[(j == 0) ? 0 : j - 1]) begin
                        r_bone[j] <= i_item.bone;
                        r_wt[j]   <= i_item.weight;
                    end else begin
                        r_bone[j] <= r_bone[(j == 0) ? 0 : j - 1];
                        r_wt[j]   <= r_wt[(j == 0) ? 0 : j - 1];
                    end
                end
            end
        end
    end

    // sequence selection and division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_idx  <= '0;
            r_kept <= '0;
            r_sum  <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (take_beat && i_item.keep) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_idx  <= '0;
                    r_kept <= '0;
                    r_sum  <= '0;
                end
                ST_SELECT: begin
                    if (sel_ok) begin
                        r_sum  <= r_sum + SW'(cur_wt);
                        r_kept <= r_kept + CW'(1);
                        r_idx  <= r_idx + CW'(1);
                    end else begin
                        r_idx <= '0;
                    end
                end
                ST_DIV: begin
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_idx <= r_idx + CW'(1);
                        if (emit_last) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // load the divider and step it one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SELECT && !sel_ok) begin
            r_rem    <= (SW + 1)'(r_wt[0] >> 1);
            r_lsb    <= r_wt[0][0];
            r_bitcnt <= '0;
            r_quo    <= '0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_rem    <= (SW + 1)'(nx_wt >> 1);
            r_lsb    <= nx_wt[0];
            r_bitcnt <= '0;
            r_quo    <= '0;
        end else if (r_state == ST_DIV) begin
            if (r_sum == '0) begin
                r_quo <= cur_wt;
            end else begin
                r_rem    <= qbit ? diff : trial;
                r_quo    <= {r_quo[WW-2:0], qbit};
                r_bitcnt <= r_bitcnt + 5'd1;
            end
        end
    end

    // hold the result until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_out_bone <= r_bone[rd_idx];
            r_out_wt   <= r_quo;
            r_out_last <= emit_last;
        end
    end

    assign o_empty      = !r_out_vld;
    assign o_bone_out   = r_out_bone;
    assign o_weight_out = r_out_wt;
    assign o_last_out   = r_out_last;

endmodule

// ===== rtl/influence_prune_renormalize.sv =====
// Top level of the influence prune/renormalize block: config port and wiring.
// Depends on ipr_pkg, ipr_front, ipr_queue and ipr_back.

// Entries of a vertex enter one per cycle through a four-beat queue, unless
// the queue is full or the back end is still busy with an earlier vertex,
// and are inserted in descending weight order (stable on ties) as they
// arrive. After the last entry the back end selects the kept entries one at
// a time, then divides each kept weight by the kept sum in a serial divider
// and hands each result to the output register, which holds it until
// popped. Entries beyond MAX_ENTRIES are dropped; a zero kept sum passes the
// weights unchanged.
module influence_prune_renormalize import ipr_pkg::*; #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [BW-1:0] i_bone_in,
    input  logic [WW-1:0] i_weight_in,
    input  logic          i_last_in,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [BW-1:0] o_bone_out,
    output logic [WW-1:0] o_weight_out,
    output logic          o_last_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [LW-1:0] r_max_inf;
    logic [WW-1:0] r_thresh;
    logic [LW-1:0] limit;
    logic          cfg_wr;
    logic          q_wr;
    logic          q_valid;
    logic          q_take;
    t_entry        f_item;
    t_entry        q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_inf <= KEEP_CAP;
            r_thresh  <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_INF) begin
                r_max_inf <= pwdata[LW-1:0];
            end else begin
                r_thresh <= pwdata[WW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_THRESH) ? {{(32 - WW){1'b0}}, r_thresh}
                                             : {{(32 - LW){1'b0}}, r_max_inf};

    // clamp the limit to one through eight
    always_comb begin
        priority if (r_max_inf == '0) begin
            limit = LW'(1);
        end else if (r_max_inf > KEEP_CAP) begin
            limit = KEEP_CAP;
        end else begin
            limit = r_max_inf;
        end
    end

    ipr_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_full      (o_full),
        .i_bone_in   (i_bone_in),
        .i_weight_in (i_weight_in),
        .i_last_in   (i_last_in),
        .o_wr        (q_wr),
        .o_item      (f_item)
    );

    ipr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (f_item),
        .o_full  (o_full),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_item  (q_item)
    );

    ipr_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_take       (q_take),
        .i_limit      (limit),
        .i_thresh     (r_thresh),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_bone_out   (o_bone_out),
        .o_weight_out (o_weight_out),
        .o_last_out   (o_last_out)
    );

`ifndef NO_ASSERTIONS
    // a renormalized weight never exceeds one
    a_weight_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_weight_out <= WW'(65536)))
        else $error("result weight above one");

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result pending after reset");

    // the clamped limit stays in range
    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (limit != '0) && (limit <= KEEP_CAP))
        else $error("influence limit out of range");
`endif

endmodule
